[sv/dif_pkg.sv]
// shared types, codes and helper functions for the dual indicator flash colour block
// no dependencies; imported by every module of the block
package dif_pkg;

    // field widths
    localparam int NOW_W      = 32;
    localparam int PERIOD_W   = 16;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_PER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT     = 3'd4;

    // reset values of the registers
    localparam logic [PERIOD_W-1:0] FAST_PER_RST = 16'd200;
    localparam logic [PERIOD_W-1:0] SLOW_PER_RST = 16'd1000;
    localparam logic [LEVEL_W-1:0]  BRIGHT_RST   = 8'd255;

    // colour levels before brightness scaling
    localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [LEVEL_W-1:0] AMBER_R    = 8'd255;
    localparam logic [LEVEL_W-1:0] AMBER_G    = 8'd80;

    // indicator modes; bit 2 marks flashing, bit 1 selects slow among flashing modes
    typedef enum logic [2:0] {
        MODE_OFF         = 3'd0,
        MODE_SOLID_RED   = 3'd1,
        MODE_SOLID_GREEN = 3'd2,
        MODE_SOLID_AMBER = 3'd3,
        MODE_FAST_RED    = 3'd4,
        MODE_FAST_GREEN  = 3'd5,
        MODE_SLOW_RED    = 3'd6,
        MODE_SLOW_GREEN  = 3'd7
    } mode_t;

    // current register contents
    typedef struct packed {
        mode_t                fault_mode;
        mode_t                ready_mode;
        logic [PERIOD_W-1:0]  fast_period;
        logic [PERIOD_W-1:0]  slow_period;
        logic [LEVEL_W-1:0]   brightness;
    } cfg_t;

    // flash state clear requests on a mode change
    typedef struct packed {
        logic fault;
        logic ready;
    } clear_t;

    // unscaled red and green of one colour
    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
    } rg_t;

    // colour that a lit indicator shows in a given mode
    function automatic rg_t mode_colour(input mode_t mode);
        rg_t c;
        c.red   = '0;
        c.green = '0;
        case (mode)
            MODE_SOLID_RED, MODE_FAST_RED, MODE_SLOW_RED:
            begin
                c.red = FULL_SCALE;
            end
            MODE_SOLID_GREEN, MODE_FAST_GREEN, MODE_SLOW_GREEN:
            begin
                c.green = FULL_SCALE;
            end
            MODE_SOLID_AMBER:
            begin
                c.red   = AMBER_R;
                c.green = AMBER_G;
            end
            default:
            begin
                c.red   = '0;
                c.green = '0;
            end
        endcase
        return c;
    endfunction

    // level * bright / 255 truncated; exact reciprocal form for 16-bit products
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [LEVEL_W-1:0] level,
                                                       input logic [LEVEL_W-1:0] bright);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = 16'(level) * 16'(bright);
        sum  = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

[sv/dif_cfg_regs.sv]
// configuration register file with mode change detection
// depends on dif_pkg
module dif_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [dif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dif_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           cfg_ready,
    output dif_pkg::cfg_t                  cfg,
    output dif_pkg::clear_t                clr
);
    import dif_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    mode_t wr_mode;

    assign cfg_ready = 1'b1;
    assign wr_mode   = mode_t'(cfg_data[2:0]);
    assign cfg       = cfg_reg;

    // decode a write transfer
    always_comb
    begin
        cfg_next  = cfg_reg;
        clr.fault = 1'b0;
        clr.ready = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FAULT_MODE:
                begin
                    if (wr_mode != cfg_reg.fault_mode)
                    begin
                        cfg_next.fault_mode = wr_mode;
                        clr.fault           = 1'b1;
                    end
                end
                REG_READY_MODE:
                begin
                    if (wr_mode != cfg_reg.ready_mode)
                    begin
                        cfg_next.ready_mode = wr_mode;
                        clr.ready           = 1'b1;
                    end
                end
                REG_FAST_PER: cfg_next.fast_period = cfg_data[PERIOD_W-1:0];
                REG_SLOW_PER: cfg_next.slow_period = cfg_data[PERIOD_W-1:0];
                REG_BRIGHT:   cfg_next.brightness  = cfg_data[LEVEL_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fault_mode  <= MODE_OFF;
            cfg_reg.ready_mode  <= MODE_OFF;
            cfg_reg.fast_period <= FAST_PER_RST;
            cfg_reg.slow_period <= SLOW_PER_RST;
            cfg_reg.brightness  <= BRIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/dif_indicator.sv]
// flash state of one indicator: flash bit, last toggle time and lit decision
// depends on dif_pkg
module dif_indicator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dif_pkg::mode_t               mode,
    input  logic [dif_pkg::PERIOD_W-1:0] fast_period,
    input  logic [dif_pkg::PERIOD_W-1:0] slow_period,
    input  logic [dif_pkg::NOW_W-1:0]    now,
    input  logic                         advance,
    input  logic                         clear,
    output logic                         lit
);
    import dif_pkg::*;

    logic                  flash_reg;
    logic                  flash_next;
    logic [NOW_W-1:0]      when_reg;
    logic [NOW_W-1:0]      when_next;
    logic [PERIOD_W-2:0]   half;
    logic [NOW_W-1:0]      elapsed;
    logic                  flashing;
    logic                  hit;

    // half period of the selected rate and wrapping elapsed time
    assign flashing = mode[2];
    assign half     = mode[1] ? slow_period[PERIOD_W-1:1] : fast_period[PERIOD_W-1:1];
    assign elapsed  = now - when_reg;
    assign hit      = elapsed >= NOW_W'(half);

    // lit flag for the item in flight
    always_comb
    begin
        if (mode == MODE_OFF)
            lit = 1'b0;
        else if (!flashing)
            lit = 1'b1;
        else
            lit = hit ? ~flash_reg : flash_reg;
    end

    // state update on a mode change or a toggle
    always_comb
    begin
        flash_next = flash_reg;
        when_next  = when_reg;
        if (clear)
        begin
            flash_next = 1'b0;
            when_next  = '0;
        end
        else if (advance && flashing && hit)
        begin
            flash_next = ~flash_reg;
            when_next  = now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_reg <= 1'b0;
            when_reg  <= '0;
        end
        else
        begin
            flash_reg <= flash_next;
            when_reg  <= when_next;
        end
    end

endmodule

[sv/dif_colour.sv]
// colour mixing with fault priority and brightness scaling
// depends on dif_pkg
module dif_colour (
    input  logic                        fault_on,
    input  logic                        ready_on,
    input  dif_pkg::mode_t              fault_mode,
    input  dif_pkg::mode_t              ready_mode,
    input  logic [dif_pkg::LEVEL_W-1:0] brightness,
    output logic [dif_pkg::LEVEL_W-1:0] red,
    output logic [dif_pkg::LEVEL_W-1:0] green,
    output logic [dif_pkg::LEVEL_W-1:0] blue
);
    import dif_pkg::*;

    rg_t mix;

    // both lit gives amber, otherwise the lit one with fault first
    always_comb
    begin
        if (fault_on && ready_on)
        begin
            mix.red   = AMBER_R;
            mix.green = AMBER_G;
        end
        else if (fault_on)
            mix = mode_colour(fault_mode);
        else if (ready_on)
            mix = mode_colour(ready_mode);
        else
        begin
            mix.red   = '0;
            mix.green = '0;
        end
    end

    // brightness scaling
    assign red   = scale_level(mix.red, brightness);
    assign green = scale_level(mix.green, brightness);
    assign blue  = '0;

endmodule

[sv/dual_indicator_flash_colour_core.sv]
// Dual indicator flash colour controller, top level.
// Depends on dif_pkg, dif_cfg_regs, dif_indicator and dif_colour.
//
// Usage:
//   Input channel (in_valid, in_stall, now_ms) carries one millisecond
//   timestamp per tick. Output channel (out_valid, out_stall, fault_on,
//   ready_on, red_level, green_level, blue_level) returns one result per tick.
//   A transfer happens on a rising edge with valid high and stall low.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes the mode, period and brightness registers; cfg_ready is always
//   high. Write it only while no tick is in flight.
// Timing:
//   An input transfer lands the timestamp in an input register; the flash
//   compare, toggle and colour mix then go into the result register once
//   it is free. One tick per clock is sustained while out_stall stays low;
//   the flash state update closes in the second stage as each tick advances.
// Reset:
//   rst_n clears the valid flags of both pipeline stages, the flash bits
//   and toggle times, and loads the register defaults (modes off, periods
//   200 and 1000, full brightness).
// Stall:
//   A stalled result holds in the output register; one more tick is taken
//   into the input register, after which in_stall rises until the result moves.
module dual_indicator_flash_colour_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dif_pkg::NOW_W-1:0]      now_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           fault_on,
    output logic                           ready_on,
    output logic [dif_pkg::LEVEL_W-1:0]    red_level,
    output logic [dif_pkg::LEVEL_W-1:0]    green_level,
    output logic [dif_pkg::LEVEL_W-1:0]    blue_level,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dif_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dif_pkg::*;

    cfg_t               cfg;
    clear_t             clr;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [NOW_W-1:0]   s1_now_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               fault_on_reg;
    logic               ready_on_reg;
    logic [LEVEL_W-1:0] red_reg;
    logic [LEVEL_W-1:0] green_reg;
    logic [LEVEL_W-1:0] blue_reg;
    logic               in_xfer;
    logic               advance;
    logic               f_lit;
    logic               r_lit;
    logic [LEVEL_W-1:0] red_mix;
    logic [LEVEL_W-1:0] green_mix;
    logic [LEVEL_W-1:0] blue_mix;

    // register file
    dif_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg),
        .clr       (clr)
    );

    // pipeline handshake
    assign advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !advance;
    assign in_xfer        = in_valid && !in_stall;
    assign s1_valid_next  = in_xfer || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // indicator state
    dif_indicator u_fault (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (cfg.fault_mode),
        .fast_period (cfg.fast_period),
        .slow_period (cfg.slow_period),
        .now         (s1_now_reg),
        .advance     (advance),
        .clear       (clr.fault),
        .lit         (f_lit)
    );

    dif_indicator u_ready (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (cfg.ready_mode),
        .fast_period (cfg.fast_period),
        .slow_period (cfg.slow_period),
        .now         (s1_now_reg),
        .advance     (advance),
        .clear       (clr.ready),
        .lit         (r_lit)
    );

    // colour mix
    dif_colour u_colour (
        .fault_on   (f_lit),
        .ready_on   (r_lit),
        .fault_mode (cfg.fault_mode),
        .ready_mode (cfg.ready_mode),
        .brightness (cfg.brightness),
        .red        (red_mix),
        .green      (green_mix),
        .blue       (blue_mix)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_now_reg <= now_ms;
        if (advance)
        begin
            fault_on_reg <= f_lit;
            ready_on_reg <= r_lit;
            red_reg      <= red_mix;
            green_reg    <= green_mix;
            blue_reg     <= blue_mix;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fault_on    = fault_on_reg;
    assign ready_on    = ready_on_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

endmodule

[sv/dif_checker.sv]
// port level checks for the dual indicator flash colour top level
// depends on dif_pkg; bound to dual_indicator_flash_colour_core
module dif_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        fault_on,
    input logic                        ready_on,
    input logic [dif_pkg::LEVEL_W-1:0] red_level,
    input logic [dif_pkg::LEVEL_W-1:0] green_level,
    input logic [dif_pkg::LEVEL_W-1:0] blue_level
);
    import dif_pkg::*;

    // a stalled result stays valid and unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fault_on) && $stable(ready_on)
            && $stable(red_level) && $stable(green_level))
        else $error("stalled result changed");

    // blue channel is never used
    a_blue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blue_level == '0)
        else $error("blue level not zero");

    // nothing lit means dark
    a_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fault_on && !ready_on |-> red_level == '0 && green_level == '0)
        else $error("colour shown with no indicator lit");

    // both lit is amber: green never above red
    a_amber: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_on && ready_on |-> green_level <= red_level)
        else $error("combined colour is not amber");

endmodule

bind dual_indicator_flash_colour_core dif_checker u_dif_checker (.*);

[bench/dual_indicator_flash_colour_core_tb.sv]
// self-checking bench for dual_indicator_flash_colour_core: directed table, then random phases
// depends on dif_pkg and the core; a local flash and colour predictor checks every result
`timescale 1ns / 100ps

module dual_indicator_flash_colour_core_tb;
    import dif_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int SETTLE       = 3;
    localparam int FAULT        = 0;
    localparam int READY        = 1;

    // indexes past the last register, decoded as no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic               fault_on;
        logic               ready_on;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } light_t;

    typedef enum logic {
        ROW_CFG,
        ROW_TICK
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [NOW_W-1:0]      now;
        logic                  chk;
        logic                  fon;
        logic                  ron;
        logic [LEVEL_W-1:0]    red;
        logic [LEVEL_W-1:0]    green;
    } dir_row_t;

    localparam int DIR_N = 43;

    // kind, index, data, now, typed check, fault_on, ready_on, red, green
    localparam dir_row_t DIRECTED [DIR_N] = '{
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd0, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAULT_MODE, 16'(MODE_SOLID_RED), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 8'd255, 8'd0},
        '{ROW_CFG, REG_READY_MODE, 16'(MODE_SOLID_GREEN), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'h1234_5678, 1'b1, 1'b1, 1'b1, 8'd255, 8'd80},
        '{ROW_CFG, REG_BRIGHT, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'hAAAA_5555, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0},
        '{ROW_CFG, REG_BRIGHT, 16'hFF80, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'h5555_AAAA, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAULT_MODE, 16'(MODE_OFF), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd7, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_READY_MODE, 16'(MODE_SOLID_AMBER), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd8, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_BRIGHT, 16'd255, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAST_PER, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAULT_MODE, {13'h1FFF, MODE_FAST_RED}, 32'd0,
          1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd5, 1'b1, 1'b1, 1'b1, 8'd255, 8'd80},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd5, 1'b1, 1'b0, 1'b1, 8'd255, 8'd80},
        '{ROW_CFG, REG_READY_MODE, 16'(MODE_OFF), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAST_PER, 16'd1, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd6, 1'b1, 1'b1, 1'b0, 8'd255, 8'd0},
        '{ROW_CFG, REG_FAULT_MODE, 16'(MODE_FAST_RED), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd6, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_SLOW_PER, 16'hFFFF, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_READY_MODE, 16'(MODE_SLOW_GREEN), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd32766, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd32767, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_SPARE_LO, 16'hFFFF, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_SPARE_HI, 16'h0000, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd100, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAULT_MODE, 16'(MODE_FAST_GREEN), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAST_PER, 16'd2, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd1, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAULT_MODE, 16'(MODE_SLOW_RED), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_FAST_PER, 16'hFFFF, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd40000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_SLOW_PER, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd40000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd40000, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_CFG, REG_READY_MODE, 16'(MODE_FAST_GREEN), 32'd0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0},
        '{ROW_TICK, REG_FAULT_MODE, 16'd0, 32'd32767, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [NOW_W-1:0]      now_ms      = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  fault_on;
    logic                  ready_on;
    logic [LEVEL_W-1:0]    red_level;
    logic [LEVEL_W-1:0]    green_level;
    logic [LEVEL_W-1:0]    blue_level;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // predictor copy of registers and flash state
    mode_t               mode_q [2]     = '{MODE_OFF, MODE_OFF};
    logic                flash_q [2]    = '{1'b0, 1'b0};
    logic [NOW_W-1:0]    toggled_at [2] = '{32'd0, 32'd0};
    logic [PERIOD_W-1:0] fast_per       = FAST_PER_RST;
    logic [PERIOD_W-1:0] slow_per       = SLOW_PER_RST;
    logic [LEVEL_W-1:0]  bright_q       = BRIGHT_RST;

    light_t           pending_lights [$];
    light_t           want;
    int               mismatches = 0;
    int               stall_left = 0;
    bit               calm       = 1'b0;
    logic [NOW_W-1:0] clock_ms   = '0;

    dual_indicator_flash_colour_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fault_on    (fault_on),
        .ready_on    (ready_on),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // flash bit of one indicator for a tick at time t, toggling once half a period has passed
    function automatic logic step_flash(input int k, input logic [NOW_W-1:0] t);
        logic [NOW_W-1:0] half;
        if (mode_q[k] == MODE_OFF)
            return 1'b0;
        if (mode_q[k] <= MODE_SOLID_AMBER)
            return 1'b1;
        half = (mode_q[k] <= MODE_FAST_GREEN) ? NOW_W'(fast_per >> 1) : NOW_W'(slow_per >> 1);
        if (NOW_W'(t - toggled_at[k]) >= half)
        begin
            toggled_at[k] = t;
            flash_q[k]    = ~flash_q[k];
        end
        return flash_q[k];
    endfunction

    // unscaled colour of a lit indicator
    function automatic rg_t lit_colour(input mode_t m);
        rg_t c;
        c = '0;
        case (m)
            MODE_SOLID_RED, MODE_FAST_RED, MODE_SLOW_RED:
            begin
                c.red = FULL_SCALE;
            end
            MODE_SOLID_GREEN, MODE_FAST_GREEN, MODE_SLOW_GREEN:
            begin
                c.green = FULL_SCALE;
            end
            MODE_SOLID_AMBER:
            begin
                c.red   = AMBER_R;
                c.green = AMBER_G;
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    function automatic logic [LEVEL_W-1:0] dim_level(input logic [LEVEL_W-1:0] lvl);
        return LEVEL_W'((int'(lvl) * int'(bright_q)) / int'(FULL_SCALE));
    endfunction

    // lights for one tick; fault wins, both lit shows amber
    function automatic light_t predict_lights(input logic [NOW_W-1:0] t);
        light_t res;
        rg_t    c;
        logic   f;
        logic   r;
        f = step_flash(FAULT, t);
        r = step_flash(READY, t);
        if (f && r)
        begin
            c.red   = AMBER_R;
            c.green = AMBER_G;
        end
        else if (f)
            c = lit_colour(mode_q[FAULT]);
        else if (r)
            c = lit_colour(mode_q[READY]);
        else
            c = '0;
        res.fault_on = f;
        res.ready_on = r;
        res.red      = dim_level(c.red);
        res.green    = dim_level(c.green);
        res.blue     = '0;
        return res;
    endfunction

    // register write as the block sees it; a changed mode restarts its flash
    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        int    k;
        mode_t m;
        k = (idx == REG_FAULT_MODE) ? FAULT : READY;
        m = mode_t'(data[2:0]);
        case (idx)
            REG_FAULT_MODE, REG_READY_MODE:
            begin
                if (m != mode_q[k])
                begin
                    mode_q[k]     = m;
                    flash_q[k]    = 1'b0;
                    toggled_at[k] = '0;
                end
            end
            REG_FAST_PER:
            begin
                fast_per = data;
            end
            REG_SLOW_PER:
            begin
                slow_per = data;
            end
            REG_BRIGHT:
            begin
                bright_q = data[LEVEL_W-1:0];
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        $display("%0t ns: %s got %0d want %0d", $time, what, got, exp_val);
    endtask

    // one config transfer, then the channel goes quiet
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one tick transfer; typed rows override the predicted result
    task automatic send_tick(input logic [NOW_W-1:0] t, input logic typed, input light_t typed_val);
        light_t guess;
        in_valid <= 1'b1;
        now_ms   <= t;
        do @(posedge clk); while (in_stall);
        guess = predict_lights(t);
        pending_lights.push_back(typed ? typed_val : guess);
    endtask

    // drop valid and wait for every outstanding result, plus pipeline slack
    task automatic go_idle();
        in_valid <= 1'b0;
        while (pending_lights.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic sender_gap();
        int n;
        n = pick_gap();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'd3;
            4: return 16'hFFFF;
            5: return FAST_PER_RST;
            6: return SLOW_PER_RST;
            7: return 16'($urandom_range(4, 64));
            8: return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    // brightness in the low byte, junk above it
    function automatic logic [CFG_DATA_W-1:0] pick_bright();
        logic [CFG_DATA_W-1:0] d;
        d = 16'($urandom);
        case ($urandom_range(0, 4))
            0: d[LEVEL_W-1:0] = 8'd0;
            1: d[LEVEL_W-1:0] = BRIGHT_RST;
            2: d[LEVEL_W-1:0] = 8'd1;
            default: d[LEVEL_W-1:0] = 8'($urandom);
        endcase
        return d;
    endfunction

    // mode in the low bits, junk above it
    function automatic logic [CFG_DATA_W-1:0] pick_mode();
        logic [CFG_DATA_W-1:0] d;
        d = 16'($urandom);
        if ($urandom_range(0, 1) == 0)
            d[CFG_DATA_W-1:3] = '0;
        return d;
    endfunction

    // time advance: mostly near the toggle thresholds, sometimes a wild jump
    function automatic logic [NOW_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return NOW_W'($urandom_range(0, 3));
        if (r < 80)
            return NOW_W'($urandom_range(0, (fast_per >> 1) + 1));
        if (r < 95)
            return NOW_W'($urandom_range(0, (slow_per >> 1) + 1));
        return NOW_W'($urandom);
    endfunction

    // result check and output-side stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_lights.size() == 0)
                report_mismatch("result with no tick waiting", 1, 0);
            else
            begin
                want = pending_lights.pop_front();
                if (fault_on !== want.fault_on)
                    report_mismatch("fault_on", fault_on, want.fault_on);
                if (ready_on !== want.ready_on)
                    report_mismatch("ready_on", ready_on, want.ready_on);
                if (red_level !== want.red)
                    report_mismatch("red_level", red_level, want.red);
                if (green_level !== want.green)
                    report_mismatch("green_level", green_level, want.green);
                if (blue_level !== want.blue)
                    report_mismatch("blue_level", blue_level, want.blue);
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 30);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // stimulus
    initial
    begin
        int     sent;
        int     len;
        int     r;
        light_t typed_val;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                go_idle();
                cfg_write(DIRECTED[i].idx, DIRECTED[i].data);
            end
            else
            begin
                typed_val = '{DIRECTED[i].fon, DIRECTED[i].ron, DIRECTED[i].red,
                              DIRECTED[i].green, 8'd0};
                send_tick(DIRECTED[i].now, DIRECTED[i].chk, typed_val);
                sender_gap();
            end
        end

        // random phases, each with its own register settings
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            go_idle();
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                cfg_write(REG_FAULT_MODE, pick_mode());
            if ($urandom_range(0, 3) != 0)
                cfg_write(REG_READY_MODE, pick_mode());
            cfg_write(REG_FAST_PER, pick_period());
            cfg_write(REG_SLOW_PER, pick_period());
            cfg_write(REG_BRIGHT, pick_bright());
            if ($urandom_range(0, 4) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          16'($urandom));

            // time base: carry on, jump anywhere, or sit just before the wrap
            r = $urandom_range(0, 99);
            if (r < 20)
                clock_ms = NOW_W'($urandom);
            else if (r < 35)
                clock_ms = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 3000));

            len = $urandom_range(10, 150);
            repeat (len)
            begin
                if (sent >= RANDOM_ITEMS)
                    break;
                clock_ms = clock_ms + pick_step();
                send_tick(clock_ms, 1'b0, '0);
                sent++;
                if ($urandom_range(0, 199) == 0)
                    go_idle();
                else
                    sender_gap();
            end
        end

        go_idle();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
